// ----- rtl/dcm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the DC motor RK4 step block.
// Used by dcm_mul, dcm_div and dc_motor_rk4_step.
package dcm_pkg;

  localparam int FracBitsDefault = 16;
  localparam int MulAW = 37;   // width of the signed operand of the shared multiplier
  localparam int MulPW = 70;   // width of the accumulated product
  localparam int SatW  = 72;   // width of intermediate sums before clamping
  localparam int SumW  = 36;   // width of the weighted slope sums
  localparam logic [63:0] PiQ32   = 64'd13493037705;
  localparam logic [31:0] RpmFrac = 32'd2359210871;
  // floor(2^34 / 6); the product is shifted down by Recip6Shift.
  localparam logic [31:0] Recip6      = 32'hAAAAAAAA;
  localparam int          Recip6Shift = 34;

  typedef enum logic [2:0] {
    REG_RESISTANCE = 3'd0,
    REG_INDUCTANCE = 3'd1,
    REG_BACK_EMF   = 3'd2,
    REG_TORQUE_K   = 3'd3,
    REG_INERTIA    = 3'd4,
    REG_STEP_SIZE  = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_MUL_PSI,
    ST_DIV_I,
    ST_MUL_KT,
    ST_DIV_W,
    ST_SCL,
    ST_FIN_MUL,
    ST_FIN_DIV,
    ST_WRAP,
    ST_RPM,
    ST_TQ,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    VAR_I,
    VAR_W,
    VAR_TH
  } var_e;

  function automatic logic signed [31:0] sat32(input logic signed [SatW-1:0] x);
    logic signed [31:0] r;
    if (x > SatW'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (x < -SatW'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/dc_motor_rk4_step.sv -----
`timescale 1ns / 1ps
// Brushed DC motor model advanced by one RK4 step per request, top level with sequencer.
// Depends on dcm_pkg, dcm_mul and dcm_div.
//
//  channel   direction  fields (lowest bits first)
//  s_axis    in         voltage, load_torque
//  m_axis    out        current, speed, speed_rpm, angle, torque
//  cfg       in         write enable, register index, data
//
// A request is accepted only in the idle state, so a new request is not taken before the
// result of the last one is loaded into the output register; the serial divider, used
// eight times, sets most of the step time. The shared multiplier holds the sequencer for
// each product and is used 29 times. Reset clears the motor state to zero and the registers to defaults.
// A finished result waits in the output register; a new request is taken meanwhile.
module dc_motor_rk4_step #(
  parameter int FRAC_BITS = dcm_pkg::FracBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // voltage, load_torque
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // current, speed, speed_rpm, angle, torque
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import dcm_pkg::*;

  localparam int DW = FRAC_BITS + 40;
  localparam logic [63:0] TwoPi64 =
    (PiQ32 + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
  localparam logic signed [31:0] TwoPi = TwoPi64[31:0];

  logic [30:0] res_q, ind_q, psi_q, kt_q, jr_q;
  logic [31:0] h_q;

  state_e state_q, state_d;
  var_e   var_q, var_d;
  logic   iss_q, iss_d;
  logic [1:0] stage_q, stage_d;
  logic signed [31:0] volt_q, volt_d, tl_q, tl_d;
  logic signed [31:0] cur_q, cur_d, spd_q, spd_d, ang_q, ang_d;
  logic signed [31:0] si_q, si_d, sw_q, sw_d, sth_q, sth_d;
  logic signed [31:0] ki_q, ki_d, kw_q, kw_d, num_q, num_d;
  logic signed [SumW-1:0] sum_i_q, sum_i_d, sum_w_q, sum_w_d, sum_th_q, sum_th_d;
  logic signed [MulPW-1:0] t_q, t_d;
  logic signed [31:0] rpm_q, rpm_d, tq_q, tq_d;
  logic [159:0] out_q, out_d;
  logic mv_q, mv_d;

  logic mul_start, mul_done, div_start, div_done;
  logic signed [MulAW-1:0] mul_a;
  logic [31:0] mul_b;
  logic signed [MulPW-1:0] prod;
  logic signed [DW-1:0] div_num;
  logic [30:0] div_den;
  logic signed [31:0] quo;
  logic signed [MulPW-1:0] scl, inc;
  logic signed [MulPW-1:0] t_abs, q6, q6_rem, q6_fix, fin_q;
  logic mid;

  dcm_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(prod)
  );

  dcm_div #(.DW(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
      ind_q <= 31'd65536;
      psi_q <= '0;
      kt_q  <= '0;
      jr_q  <= 31'd65536;
      h_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RESISTANCE: res_q <= cfg_data_i[30:0];
        REG_INDUCTANCE: ind_q <= cfg_data_i[30:0];
        REG_BACK_EMF:   psi_q <= cfg_data_i[30:0];
        REG_TORQUE_K:   kt_q  <= cfg_data_i[30:0];
        REG_INERTIA:    jr_q  <= cfg_data_i[30:0];
        REG_STEP_SIZE:  h_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      var_q   <= VAR_I;
      iss_q   <= 1'b0;
      stage_q <= 2'd0;
      cur_q   <= '0;
      spd_q   <= '0;
      ang_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      var_q   <= var_d;
      iss_q   <= iss_d;
      stage_q <= stage_d;
      cur_q   <= cur_d;
      spd_q   <= spd_d;
      ang_q   <= ang_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    volt_q <= volt_d;  tl_q <= tl_d;
    si_q <= si_d;  sw_q <= sw_d;  sth_q <= sth_d;
    ki_q <= ki_d;  kw_q <= kw_d;  num_q <= num_d;
    sum_i_q <= sum_i_d;  sum_w_q <= sum_w_d;  sum_th_q <= sum_th_d;
    t_q <= t_d;  rpm_q <= rpm_d;  tq_q <= tq_d;  out_q <= out_d;
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a = MulAW'(si_q);
    mul_b = {1'b0, res_q};
    case (state_q)
      ST_MUL_PSI: begin mul_a = MulAW'(sw_q);  mul_b = {1'b0, psi_q}; end
      ST_MUL_KT:  begin mul_a = MulAW'(si_q);  mul_b = {1'b0, kt_q};  end
      ST_SCL: begin
        mul_b = h_q;
        case (var_q)
          VAR_TH:  mul_a = MulAW'(sw_q);
          VAR_I:   mul_a = MulAW'(ki_q);
          default: mul_a = MulAW'(kw_q);
        endcase
      end
      ST_FIN_MUL: begin
        mul_b = h_q;
        case (var_q)
          VAR_I:   mul_a = MulAW'(sum_i_q);
          VAR_W:   mul_a = MulAW'(sum_w_q);
          default: mul_a = MulAW'(sum_th_q);
        endcase
      end
      ST_FIN_DIV: begin mul_a = MulAW'(t_abs); mul_b = Recip6;  end
      ST_RPM: begin mul_a = MulAW'(spd_q); mul_b = RpmFrac;       end
      ST_TQ:  begin mul_a = MulAW'(cur_q); mul_b = {1'b0, kt_q};  end
      default: ;
    endcase
  end

  always_comb begin
    div_num = DW'(num_q) <<< FRAC_BITS;
    div_den = (ind_q == '0) ? 31'd1 : ind_q;
    case (state_q)
      ST_DIV_W: div_den = (jr_q == '0) ? 31'd1 : jr_q;
      default: ;
    endcase
  end

  assign mid = (stage_q == 2'd1) || (stage_q == 2'd2);
  assign scl = prod >>> 32;
  assign inc = (stage_q == 2'd2) ? scl : (scl >>> 1);

  // The scaled slope sum stays below 2^34 in magnitude, so the reciprocal product
  // falls short of the true quotient by six by at most one.
  assign t_abs  = t_q[MulPW-1] ? -t_q : t_q;
  assign q6     = prod >>> Recip6Shift;
  assign q6_rem = t_abs - ((q6 <<< 2) + (q6 <<< 1));
  assign q6_fix = (q6_rem >= MulPW'(6)) ? q6 + MulPW'(1) : q6;
  assign fin_q  = t_q[MulPW-1] ? -q6_fix : q6_fix;

  always_comb begin
    state_d = state_q;  var_d = var_q;  iss_d = iss_q;  stage_d = stage_q;
    volt_d = volt_q;  tl_d = tl_q;
    cur_d = cur_q;  spd_d = spd_q;  ang_d = ang_q;
    si_d = si_q;  sw_d = sw_q;  sth_d = sth_q;
    ki_d = ki_q;  kw_d = kw_q;  num_d = num_q;
    sum_i_d = sum_i_q;  sum_w_d = sum_w_q;  sum_th_d = sum_th_q;
    t_d = t_q;  rpm_d = rpm_q;  tq_d = tq_q;  out_d = out_q;
    mv_d = mv_q && !m_axis_tready;
    mul_start = 1'b0;
    div_start = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          volt_d = s_axis_tdata[31:0];
          tl_d = s_axis_tdata[63:32];
          si_d = cur_q;  sw_d = spd_q;  sth_d = ang_q;
          sum_i_d = '0;  sum_w_d = '0;  sum_th_d = '0;
          stage_d = 2'd0;
          iss_d = 1'b0;
          state_d = ST_MUL_R;
        end
      end
      ST_MUL_R, ST_MUL_PSI, ST_MUL_KT, ST_SCL, ST_FIN_MUL, ST_FIN_DIV, ST_RPM,
      ST_TQ: begin
        if (!iss_q) begin
          mul_start = 1'b1;
          iss_d = 1'b1;
        end else if (mul_done) begin
          iss_d = 1'b0;
          case (state_q)
            ST_MUL_R: begin
              t_d = prod >>> FRAC_BITS;
              state_d = ST_MUL_PSI;
            end
            ST_MUL_PSI: begin
              num_d = sat32(SatW'(volt_q) - SatW'(t_q) - SatW'(prod >>> FRAC_BITS));
              state_d = ST_DIV_I;
            end
            ST_MUL_KT: begin
              num_d = sat32(SatW'(prod >>> FRAC_BITS) - SatW'(tl_q));
              state_d = ST_DIV_W;
            end
            ST_SCL: begin
              case (var_q)
                VAR_TH: begin
                  sth_d = sat32(SatW'(ang_q) + SatW'(inc));
                  var_d = VAR_I;
                end
                VAR_I: begin
                  si_d = sat32(SatW'(cur_q) + SatW'(inc));
                  var_d = VAR_W;
                end
                default: begin
                  sw_d = sat32(SatW'(spd_q) + SatW'(inc));
                  stage_d = stage_q + 2'd1;
                  state_d = ST_MUL_R;
                end
              endcase
            end
            ST_FIN_MUL: begin
              t_d = scl;
              state_d = ST_FIN_DIV;
            end
            ST_FIN_DIV: begin
              case (var_q)
                VAR_I: begin
                  cur_d = sat32(SatW'(cur_q) + SatW'(fin_q));
                  var_d = VAR_W;
                  state_d = ST_FIN_MUL;
                end
                VAR_W: begin
                  spd_d = sat32(SatW'(spd_q) + SatW'(fin_q));
                  var_d = VAR_TH;
                  state_d = ST_FIN_MUL;
                end
                default: begin
                  ang_d = sat32(SatW'(ang_q) + SatW'(fin_q));
                  state_d = ST_WRAP;
                end
              endcase
            end
            ST_RPM: begin
              rpm_d = sat32((SatW'(spd_q) <<< 3) + SatW'(spd_q) + SatW'(scl));
              state_d = ST_TQ;
            end
            default: begin
              tq_d = sat32(SatW'(prod >>> FRAC_BITS));
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_DIV_I, ST_DIV_W: begin
        if (!iss_q) begin
          div_start = 1'b1;
          iss_d = 1'b1;
        end else if (div_done) begin
          iss_d = 1'b0;
          case (state_q)
            ST_DIV_I: begin
              ki_d = quo;
              sum_i_d = sum_i_q + (mid ? (SumW'(quo) <<< 1) : SumW'(quo));
              state_d = ST_MUL_KT;
            end
            default: begin
              kw_d = quo;
              sum_w_d = sum_w_q + (mid ? (SumW'(quo) <<< 1) : SumW'(quo));
              sum_th_d = sum_th_q + (mid ? (SumW'(sw_q) <<< 1) : SumW'(sw_q));
              if (stage_q == 2'd3) begin
                var_d = VAR_I;
                state_d = ST_FIN_MUL;
              end else begin
                var_d = VAR_TH;
                state_d = ST_SCL;
              end
            end
          endcase
        end
      end
      ST_WRAP: begin
        if (ang_q > TwoPi) begin
          ang_d = ang_q - TwoPi;
        end else if (ang_q < 0) begin
          ang_d = ang_q + TwoPi;
        end
        state_d = ST_RPM;
      end
      ST_OUT: begin
        if (!mv_q || m_axis_tready) begin
          out_d = {tq_q, ang_q, rpm_q, spd_q, cur_q};
          mv_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = out_q;

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q != ST_IDLE)
    else $error("sequencer idle after accepting a request");
  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result appeared outside the output state");
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("result not loaded into output register");

endmodule

// ----- rtl/dcm_mul.sv -----
`timescale 1ns / 1ps
// Shared multiplier: signed operand times 32-bit unsigned operand in two 16-bit halves.
// Depends on dcm_pkg.
module dcm_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [dcm_pkg::MulAW-1:0] a_i,
  input  logic        [31:0]               b_i,
  output logic                             done_o,
  output logic signed [dcm_pkg::MulPW-1:0] prod_o
);
  import dcm_pkg::*;

  logic signed [MulAW-1:0] a_q;
  logic        [31:0]      b_q;
  logic        [1:0]       ph_q;
  logic                    done_q;
  logic signed [MulPW-1:0] prod_q;
  logic signed [MulAW+16:0] pp;
  logic        [15:0]      half;

  assign half = (ph_q == 2'd1) ? b_q[15:0] : b_q[31:16];
  assign pp   = a_q * $signed({1'b0, half});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ph_q <= 2'd1;
      end else if (ph_q == 2'd1) begin
        ph_q <= 2'd2;
      end else if (ph_q == 2'd2) begin
        ph_q   <= 2'd0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (ph_q == 2'd1) begin
      prod_q <= MulPW'(pp);
    end else if (ph_q == 2'd2) begin
      prod_q <= prod_q + (MulPW'(pp) <<< 16);
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ----- rtl/dcm_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider, truncating toward zero, quotient clamped to 32 bits.
// Depends on dcm_pkg.
module dcm_div #(
  parameter int DW = 56
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] num_i,
  input  logic        [30:0]   den_i,
  output logic                 done_o,
  output logic signed [31:0]   quo_o
);
  import dcm_pkg::*;

  logic [DW:0]    mag;
  logic [DW-32:0] mag_hi;
  logic [30:0]    den_q, rem_q;
  logic [31:0]    low_q, q_q;
  logic           neg_q, ovf_q, busy_q, done_q;
  logic [4:0]     cnt_q;
  logic [31:0]    r2;
  logic           ge;

  assign mag    = num_i[DW-1] ? -(DW+1)'(num_i) : (DW+1)'(num_i);
  assign mag_hi = mag[DW:32];
  assign r2     = {rem_q, low_q[31]};
  assign ge     = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[DW-1];
      ovf_q <= (DW+1)'(mag_hi) >= (DW+1)'(den_i);
      rem_q <= 31'(mag_hi);
      low_q <= mag[31:0];
      q_q   <= 32'd0;
    end else if (busy_q) begin
      rem_q <= ge ? 31'(r2 - {1'b0, den_q}) : r2[30:0];
      low_q <= {low_q[30:0], 1'b0};
      q_q   <= {q_q[30:0], ge};
    end
  end

  always_comb begin
    if (ovf_q) begin
      quo_o = neg_q ? 32'sh80000000 : 32'sh7fffffff;
    end else if (neg_q) begin
      quo_o = (q_q > 32'h80000000) ? 32'sh80000000 : -$signed(q_q);
    end else begin
      quo_o = q_q[31] ? 32'sh7fffffff : $signed(q_q);
    end
  end

  assign done_o = done_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for dc_motor_rk4_step: random stream traffic, a fixed-point motor model.
// Depends on dcm_pkg and the RTL of the block; nothing else is read.

typedef struct packed {
  logic signed [31:0] torque;
  logic signed [31:0] angle;
  logic signed [31:0] speed_rpm;
  logic signed [31:0] speed;
  logic signed [31:0] current;
} motor_result_t;

class motor_scoreboard;
  localparam int FB = 16;
  localparam longint RpmInt = 9;

  logic [31:0] res_r, ind_l, psi_k, kt_k, jm_k, step_h;
  longint cur_i, spd_w, ang_th;
  motor_result_t expected_q[$];
  int mismatches;
  int results_seen;

  function new();
    res_r = 0; ind_l = 65536; psi_k = 0; kt_k = 0; jm_k = 65536; step_h = 0;
    cur_i = 0; spd_w = 0; ang_th = 0;
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      dcm_pkg::REG_RESISTANCE: res_r = {1'b0, data[30:0]};
      dcm_pkg::REG_INDUCTANCE: ind_l = {1'b0, data[30:0]};
      dcm_pkg::REG_BACK_EMF:   psi_k = {1'b0, data[30:0]};
      dcm_pkg::REG_TORQUE_K:   kt_k  = {1'b0, data[30:0]};
      dcm_pkg::REG_INERTIA:    jm_k  = {1'b0, data[30:0]};
      dcm_pkg::REG_STEP_SIZE:  step_h = data;
      default: ;
    endcase
  endfunction

  function longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function longint fmul(longint a, logic [31:0] c);
    return (a * longint'({32'd0, c})) >>> FB;
  endfunction

  function longint by_step(longint v);
    longint hi, lo;
    hi = v * longint'({48'd0, step_h[31:16]});
    lo = (v * longint'({48'd0, step_h[15:0]})) >>> 16;
    return (hi + lo) >>> 16;
  endfunction

  // A zero divisor counts as one LSB.
  function longint fdiv(longint n, logic [31:0] d);
    longint dd;
    dd = (d == 0) ? 1 : longint'({32'd0, d});
    return clamp32((n * 65536) / dd);
  endfunction

  function void slopes(longint u, longint tl, longint xi, longint xw,
                       output longint ki, output longint kw, output longint kth);
    ki = fdiv(clamp32(u - fmul(xi, res_r) - fmul(xw, psi_k)), ind_l);
    kw = fdiv(clamp32(fmul(xi, kt_k) - tl), jm_k);
    kth = xw;
  endfunction

  function void note_request(logic [63:0] req);
    longint u, tl, two_pi;
    longint k1i, k1w, k1t, k2i, k2w, k2t, k3i, k3w, k3t, k4i, k4w, k4t;
    longint ni, nw, nth;
    longint rpm_v, tq_v;
    motor_result_t r;
    u = longint'($signed(req[31:0]));
    tl = longint'($signed(req[63:32]));
    two_pi = longint'((dcm_pkg::PiQ32 + (64'd1 << 14)) >> 15);
    slopes(u, tl, cur_i, spd_w, k1i, k1w, k1t);
    slopes(u, tl, clamp32(cur_i + (by_step(k1i) >>> 1)),
           clamp32(spd_w + (by_step(k1w) >>> 1)), k2i, k2w, k2t);
    slopes(u, tl, clamp32(cur_i + (by_step(k2i) >>> 1)),
           clamp32(spd_w + (by_step(k2w) >>> 1)), k3i, k3w, k3t);
    slopes(u, tl, clamp32(cur_i + by_step(k3i)),
           clamp32(spd_w + by_step(k3w)), k4i, k4w, k4t);
    // The angle stage values only feed the slopes through w, so they are not kept.
    ni = clamp32(cur_i + by_step(k1i + 2 * k2i + 2 * k3i + k4i) / 6);
    nw = clamp32(spd_w + by_step(k1w + 2 * k2w + 2 * k3w + k4w) / 6);
    nth = clamp32(ang_th + by_step(k1t + 2 * k2t + 2 * k3t + k4t) / 6);
    if (nth > two_pi) begin
      nth -= two_pi;
    end else if (nth < 0) begin
      nth += two_pi;
    end
    cur_i = ni; spd_w = nw; ang_th = nth;
    rpm_v = clamp32(nw * RpmInt
            + ((nw * longint'({32'd0, dcm_pkg::RpmFrac})) >>> 32));
    tq_v = clamp32(fmul(ni, kt_k));
    r.current = ni[31:0];
    r.speed = nw[31:0];
    r.angle = nth[31:0];
    r.speed_rpm = rpm_v[31:0];
    r.torque = tq_v[31:0];
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [159:0] data);
    motor_result_t got, exp_r;
    got = data;
    results_seen++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with nothing pending: %h", data);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result %0d mismatch", results_seen);
        $display("  current exp %0d got %0d, speed exp %0d got %0d",
                 exp_r.current, got.current, exp_r.speed, got.speed);
        $display("  rpm exp %0d got %0d, angle exp %0d got %0d, torque exp %0d got %0d",
                 exp_r.speed_rpm, got.speed_rpm, exp_r.angle, got.angle,
                 exp_r.torque, got.torque);
      end
    end
  endfunction
endclass

module tb_top;
  import dcm_pkg::*;

  localparam logic [2:0] RegUnused = 3'd6;
  localparam logic [2:0] RegUnusedTop = 3'd7;
  localparam int VoltSpan = 48 * 65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  motor_scoreboard motor_sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int requests_sent = 0;

  always #10 clk_i = ~clk_i;

  dc_motor_rk4_step dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Receiver: random stalls, plus a long hold-off when asked for.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 4000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) motor_sb.check_result(m_axis_tdata);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    motor_sb.write_reg(idx, data);
  endtask

  task automatic send_request(logic signed [31:0] volt, logic signed [31:0] load);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {load, volt};
    do @(posedge clk_i); while (!s_axis_tready);
    motor_sb.note_request({load, volt});
    requests_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (motor_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_motor(logic [31:0] r, logic [31:0] l, logic [31:0] psi,
                           logic [31:0] kt, logic [31:0] j, logic [31:0] h);
    write_reg(REG_RESISTANCE, r);
    write_reg(REG_INDUCTANCE, l);
    write_reg(REG_BACK_EMF, psi);
    write_reg(REG_TORQUE_K, kt);
    write_reg(REG_INERTIA, j);
    write_reg(REG_STEP_SIZE, h);
  endtask

  // Mostly plausible drive levels so the state evolves, with full-range noise mixed in.
  task automatic random_requests(int count);
    logic signed [31:0] volt, load;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        volt = $signed($urandom_range(0, 2 * VoltSpan)) - VoltSpan;
        load = $signed($urandom_range(0, 2 * 65536)) - 65536;
      end else begin
        volt = $urandom();
        load = $urandom();
      end
      send_request(volt, load);
    end
  endtask

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: zero step, state must stay put.
    send_request(32'sd12 << 16, 32'sd0);
    send_request(32'h7fffffff, 32'h80000000);
    wait_drained();

    // Small motor, directed extremes of both inputs.
    set_motor(65536, 655, 3277, 3277, 66, 32'd429497);
    send_request(32'h7fffffff, 32'h0);
    send_request(32'h80000000, 32'h0);
    send_request(32'h0, 32'h7fffffff);
    send_request(32'h0, 32'h80000000);
    send_request(32'hffffffff, 32'hffffffff);
    send_request(32'sd24 << 16, 32'sd0);
    for (int n = 0; n < 6; n++) send_request(32'sd24 << 16, 32'sd1 << 14);
    send_request(-(32'sd24 << 16), 32'sd0);
    wait_drained();

    // Register extremes; bit 31 set on 31-bit registers must be dropped.
    set_motor(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff);
    send_request(32'h7fffffff, 32'h80000000);
    send_request(32'h80000000, 32'h7fffffff);
    send_request(32'sd1 << 16, 32'sd0);
    wait_drained();

    // Zero divisors, fast spin to force angle wrap both ways; writes to unused indexes.
    set_motor(0, 32'h80000000, 0, 65536, 0, 32'hffffffff);
    write_reg(RegUnused, 32'h12345678);
    write_reg(RegUnusedTop, 32'hffffffff);
    send_request(32'sd1 << 16, -(32'sd3 << 14));
    send_request(32'sd1 << 16, 32'sd3 << 14);
    send_request(32'sd0, 32'sd5 << 14);
    send_request(32'sd0, -(32'sd5 << 14));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) idle_on = 1'b0;
      set_motor($urandom_range(0, 5 << 16), $urandom_range(0, 65536),
                $urandom_range(0, 65536), $urandom_range(0, 65536),
                $urandom_range(0, 65536), $urandom_range(1 << 10, 1 << 24));
      if (ph == 2) hold_req = 1'b1;
      random_requests(200);
      wait_drained();
    end

    repeat (600) @(posedge clk_i);
    $display("Run covered %0d motor steps, %0d results checked, over 12 register settings,",
             requests_sent, motor_sb.results_seen);
    $display("including zero divisors, full-scale inputs and a long output hold-off.");
    if (motor_sb.mismatches == 0 && motor_sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", motor_sb.mismatches,
               motor_sb.expected_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
